FILE: hdl/stepper_turnout_positioner_assert.svh
// ---------------------------------------------------------------------------
// stepper turnout positioner assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef STEPPER_TURNOUT_POSITIONER_ASSERT_SVH
`define STEPPER_TURNOUT_POSITIONER_ASSERT_SVH

// same-cycle implication, off during reset
`define STP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper positioner check failed");

// next-cycle implication, off during reset
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper positioner check failed");

// next-cycle implication, also checked across reset
`define STP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stepper positioner check failed");

`endif

FILE: hdl/stp_pkg.sv
// ---------------------------------------------------------------------------
// stp_pkg
// types, constants and coil pattern table of the stepper turnout positioner
// ---------------------------------------------------------------------------
package stp_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int TICK_BITS_DEFAULT     = 20;
   localparam int PATTERN_COUNT         = 4;
   localparam int STEP_PERIOD_RESET     = 1000;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int CMD_BITS              = 2;
   localparam int MODE_BITS             = 3;
   localparam int COIL_BITS             = 4;

   localparam logic [1:0] PATTERN_FIRST = 2'd0;
   localparam logic [1:0] PATTERN_LAST  = 2'(PATTERN_COUNT - 1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_TARGET = 2'd1,
      CMD_ATTACH     = 2'd2
   } cmd_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_IDLE      = 3'd0,
      MODE_SEEK_END  = 3'd1,
      MODE_MEASURE   = 3'd2,
      MODE_STORE     = 3'd3,
      MODE_CORR_WAIT = 3'd4,
      MODE_CORR_JOG  = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_PERIOD   = 2'd0,
      CSR_STORED_TRAVEL = 2'd1,
      CSR_START_SIDE    = 2'd2
   } csr_index_type;

   localparam logic SIDE_RIGHT = 1'b0;
   localparam logic SIDE_LEFT  = 1'b1;

   localparam logic [COIL_BITS-1:0] COILS_OFF = 4'h0;

   // full-step coil pattern: bit3 A+, bit2 A-, bit1 B+, bit0 B-
   function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [1:0] idx);
      logic [COIL_BITS-1:0] pat;
      unique case (idx)
         2'd0: pat = 4'h9;
         2'd1: pat = 4'h5;
         2'd2: pat = 4'h6;
         2'd3: pat = 4'hA;
      endcase
      return pat;
   endfunction

endpackage

FILE: hdl/stp_core.sv
// ---------------------------------------------------------------------------
// stp_core
// control registers, configuration registers and per-item next-state logic
// ---------------------------------------------------------------------------
module stp_core
   import stp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int TICK_BITS     = TICK_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [(TICK_BITS > POSITION_BITS ? TICK_BITS : POSITION_BITS)-1:0] csr_wdata,
   input  logic                     accept,
   input  logic [CMD_BITS-1:0]      cmd,
   input  logic                     target_side,
   input  logic                     step_button,
   input  logic                     correction_button,
   output logic [COIL_BITS-1:0]     nxt_coils,
   output logic [POSITION_BITS-1:0] nxt_position,
   output logic [MODE_BITS-1:0]     nxt_mode,
   output logic                     nxt_moving,
   output logic                     nxt_calibrated,
   output logic                     nxt_correcting,
   output logic [POSITION_BITS-1:0] nxt_travel,
   output logic                     nxt_side
);

   localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
   localparam logic [TICK_BITS-1:0]     TICK_ONE = TICK_BITS'(1);

   // configuration
   logic [TICK_BITS-1:0]     step_period_ff;
   logic [POSITION_BITS-1:0] stored_travel_ff;
   logic                     start_side_ff;

   // control state
   mode_type                 mode_ff,       mode_in;
   logic [1:0]               pattern_ff,    pattern_in;
   logic                     reverse_ff,    reverse_in;
   logic [TICK_BITS-1:0]     tick_ff,       tick_in;
   logic [POSITION_BITS-1:0] cur_pos_ff,    cur_pos_in;
   logic [POSITION_BITS-1:0] target_ff,     target_in;
   logic [POSITION_BITS-1:0] left_pos_ff,   left_pos_in;
   logic [POSITION_BITS-1:0] measure_ff,    measure_in;
   logic                     move_up_ff,    move_up_in;
   logic                     enable_ff,     enable_in;
   logic                     calib_ff,      calib_in;
   logic                     corr_ff,       corr_in;
   logic [COIL_BITS-1:0]     coil_ff,       coil_in;
   logic                     side_ff,       side_in;

   logic [TICK_BITS-1:0]     tick_inc;
   logic                     due;
   logic                     pending;
   logic [1:0]               step_pattern;
   logic [COIL_BITS-1:0]     step_coil;
   logic [POSITION_BITS-1:0] moved_pos;
   cmd_type                  cmd_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff   <= TICK_BITS'(STEP_PERIOD_RESET);
         stored_travel_ff <= '0;
         start_side_ff    <= SIDE_RIGHT;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_PERIOD:   step_period_ff   <= csr_wdata[TICK_BITS-1:0];
            CSR_STORED_TRAVEL: stored_travel_ff <= csr_wdata[POSITION_BITS-1:0];
            CSR_START_SIDE:    start_side_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd_op       = cmd_type'(cmd);
      tick_inc     = (&tick_ff) ? tick_ff : tick_ff + TICK_ONE;
      due          = (tick_inc >= step_period_ff);
      pending      = enable_ff && (target_ff != cur_pos_ff);
      step_coil    = coil_pattern(pattern_ff);
      step_pattern = reverse_ff ? pattern_ff - 2'd1 : pattern_ff + 2'd1;
      moved_pos    = move_up_ff ? cur_pos_ff + POS_ONE : cur_pos_ff - POS_ONE;
   end

   always_comb begin
      mode_in     = mode_ff;
      pattern_in  = pattern_ff;
      reverse_in  = reverse_ff;
      tick_in     = tick_ff;
      cur_pos_in  = cur_pos_ff;
      target_in   = target_ff;
      left_pos_in = left_pos_ff;
      measure_in  = measure_ff;
      move_up_in  = move_up_ff;
      enable_in   = enable_ff;
      calib_in    = calib_ff;
      corr_in     = corr_ff;
      coil_in     = coil_ff;
      side_in     = side_ff;

      unique case (cmd_op)
         CMD_TICK: begin
            tick_in = tick_inc;
            if (pending) begin
               if (due) begin
                  tick_in    = '0;
                  coil_in    = step_coil;
                  pattern_in = step_pattern;
                  cur_pos_in = moved_pos;
                  if (moved_pos == target_ff) begin
                     coil_in = COILS_OFF;
                  end
               end
            end else begin
               unique case (mode_ff)
                  MODE_IDLE: begin
                     if (step_button) begin
                        enable_in  = 1'b0;
                        mode_in    = MODE_SEEK_END;
                        reverse_in = 1'b1;
                        pattern_in = PATTERN_LAST;
                     end
                     if (correction_button) begin
                        mode_in = MODE_CORR_WAIT;
                        corr_in = 1'b1;
                     end
                  end
                  MODE_SEEK_END: begin
                     if (due) begin
                        tick_in    = '0;
                        coil_in    = step_coil;
                        pattern_in = step_pattern;
                     end
                     if (step_button) begin
                        mode_in    = MODE_MEASURE;
                        reverse_in = 1'b0;
                        pattern_in = PATTERN_FIRST;
                        measure_in = '0;
                        coil_in    = COILS_OFF;
                     end
                  end
                  MODE_MEASURE: begin
                     if (due) begin
                        tick_in    = '0;
                        coil_in    = step_coil;
                        pattern_in = step_pattern;
                        if (!(&measure_ff)) begin
                           measure_in = measure_ff + POS_ONE;
                        end
                     end
                     if (step_button) begin
                        mode_in = MODE_STORE;
                     end
                  end
                  MODE_STORE: begin
                     coil_in     = COILS_OFF;
                     enable_in   = 1'b1;
                     left_pos_in = measure_ff;
                     mode_in     = MODE_IDLE;
                     side_in     = SIDE_LEFT;
                     target_in   = measure_ff;
                     move_up_in  = 1'b1;
                     pattern_in  = PATTERN_FIRST;
                     reverse_in  = 1'b1;
                     cur_pos_in  = POS_ZERO;
                     calib_in    = 1'b1;
                  end
                  MODE_CORR_WAIT: begin
                     if (step_button) begin
                        mode_in    = MODE_CORR_JOG;
                        reverse_in = 1'b0;
                     end
                     if (correction_button) begin
                        mode_in    = MODE_CORR_JOG;
                        reverse_in = 1'b1;
                     end
                  end
                  MODE_CORR_JOG: begin
                     if (due) begin
                        tick_in    = '0;
                        coil_in    = step_coil;
                        pattern_in = step_pattern;
                     end
                     if (step_button || correction_button) begin
                        mode_in   = MODE_IDLE;
                        coil_in   = COILS_OFF;
                        enable_in = 1'b0;
                        calib_in  = 1'b0;
                        corr_in   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_SET_TARGET: begin
            side_in = target_side;
            tick_in = '0;
            if (target_side) begin
               target_in  = left_pos_ff;
               move_up_in = 1'b1;
               pattern_in = PATTERN_FIRST;
               reverse_in = 1'b1;
            end else begin
               target_in  = POS_ZERO;
               move_up_in = 1'b0;
               pattern_in = PATTERN_LAST;
               reverse_in = 1'b0;
            end
         end
         CMD_ATTACH: begin
            coil_in     = COILS_OFF;
            tick_in     = '1;
            mode_in     = MODE_IDLE;
            enable_in   = (stored_travel_ff != POS_ZERO);
            calib_in    = 1'b0;
            corr_in     = 1'b0;
            left_pos_in = stored_travel_ff;
            side_in     = start_side_ff;
            cur_pos_in  = start_side_ff ? stored_travel_ff : POS_ZERO;
            target_in   = start_side_ff ? stored_travel_ff : POS_ZERO;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pattern_ff  <= '0;
         reverse_ff  <= 1'b0;
         tick_ff     <= '0;
         cur_pos_ff  <= '0;
         target_ff   <= '0;
         left_pos_ff <= '0;
         measure_ff  <= '0;
         move_up_ff  <= 1'b0;
         enable_ff   <= 1'b0;
         calib_ff    <= 1'b0;
         corr_ff     <= 1'b0;
         coil_ff     <= COILS_OFF;
         side_ff     <= SIDE_RIGHT;
      end else if (accept) begin
         mode_ff     <= mode_in;
         pattern_ff  <= pattern_in;
         reverse_ff  <= reverse_in;
         tick_ff     <= tick_in;
         cur_pos_ff  <= cur_pos_in;
         target_ff   <= target_in;
         left_pos_ff <= left_pos_in;
         measure_ff  <= measure_in;
         move_up_ff  <= move_up_in;
         enable_ff   <= enable_in;
         calib_ff    <= calib_in;
         corr_ff     <= corr_in;
         coil_ff     <= coil_in;
         side_ff     <= side_in;
      end
   end

   assign nxt_coils      = coil_in;
   assign nxt_position   = cur_pos_in;
   assign nxt_mode       = mode_in;
   assign nxt_moving     = enable_in && (cur_pos_in != target_in);
   assign nxt_calibrated = calib_in;
   assign nxt_correcting = corr_in;
   assign nxt_travel     = left_pos_in;
   assign nxt_side       = side_in;

endmodule

FILE: hdl/stp_rsp_reg.sv
// ---------------------------------------------------------------------------
// stp_rsp_reg
// result register with valid/ready handshake, refills while being drained
// ---------------------------------------------------------------------------
module stp_rsp_reg
   import stp_pkg::*;
#(
   parameter int WIDTH = 2 * POSITION_BITS_DEFAULT + COIL_BITS + MODE_BITS + 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;
   logic             load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/stepper_turnout_positioner.sv
// ---------------------------------------------------------------------------
// stepper_turnout_positioner
// full-step bipolar stepper controller with travel calibration and jogging
// ---------------------------------------------------------------------------
// One request is taken per clock cycle while the result register can take
// it. Each request (tick, set target side or attach) updates the controller
// state in the cycle it is transferred and its response appears in the
// result register on the next cycle; the request side stays ready while that
// register is empty or being drained in the same cycle, so the sustained rate
// is one item per cycle unless results are held. Configuration writes take
// effect on the next edge and must be made while no request is in flight.
module stepper_turnout_positioner
   import stp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int TICK_BITS     = TICK_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [(TICK_BITS > POSITION_BITS ? TICK_BITS : POSITION_BITS)-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_BITS-1:0]       req_cmd,
   input  logic                      req_target_side,
   input  logic                      req_step_button,
   input  logic                      req_correction_button,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COIL_BITS-1:0]      rsp_coils,
   output logic [POSITION_BITS-1:0]  rsp_position,
   output logic [MODE_BITS-1:0]      rsp_mode,
   output logic                      rsp_moving,
   output logic                      rsp_calibrated,
   output logic                      rsp_correcting,
   output logic [POSITION_BITS-1:0]  rsp_travel,
   output logic                      rsp_side
);

   localparam int RSP_BITS = 2 * POSITION_BITS + COIL_BITS + MODE_BITS + 4;

   logic                     accept;
   logic [COIL_BITS-1:0]     nxt_coils;
   logic [POSITION_BITS-1:0] nxt_position;
   logic [MODE_BITS-1:0]     nxt_mode;
   logic                     nxt_moving;
   logic                     nxt_calibrated;
   logic                     nxt_correcting;
   logic [POSITION_BITS-1:0] nxt_travel;
   logic                     nxt_side;
   logic [RSP_BITS-1:0]      rsp_in_data;
   logic [RSP_BITS-1:0]      rsp_out_data;

   assign accept = req_valid && req_ready;

   stp_core #(
      .POSITION_BITS (POSITION_BITS),
      .TICK_BITS     (TICK_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .accept            (accept),
      .cmd               (req_cmd),
      .target_side       (req_target_side),
      .step_button       (req_step_button),
      .correction_button (req_correction_button),
      .nxt_coils         (nxt_coils),
      .nxt_position      (nxt_position),
      .nxt_mode          (nxt_mode),
      .nxt_moving        (nxt_moving),
      .nxt_calibrated    (nxt_calibrated),
      .nxt_correcting    (nxt_correcting),
      .nxt_travel        (nxt_travel),
      .nxt_side          (nxt_side)
   );

   assign rsp_in_data = {nxt_coils, nxt_position, nxt_mode, nxt_moving,
                         nxt_calibrated, nxt_correcting, nxt_travel, nxt_side};

   stp_rsp_reg #(
      .WIDTH (RSP_BITS)
   ) u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_in_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out_data)
   );

   assign {rsp_coils, rsp_position, rsp_mode, rsp_moving,
           rsp_calibrated, rsp_correcting, rsp_travel, rsp_side} = rsp_out_data;

endmodule

FILE: hdl/stp_checker.sv
// ---------------------------------------------------------------------------
// stp_checker
// port-level checks of the stepper turnout positioner, bound to the top level
// ---------------------------------------------------------------------------
`include "stepper_turnout_positioner_assert.svh"

module stp_checker
   import stp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [POSITION_BITS-1:0] rsp_position,
   input logic [MODE_BITS-1:0]     rsp_mode,
   input logic                     rsp_correcting
);

   logic corr_mode;
   logic rsp_held;

   assign corr_mode = (rsp_mode == MODE_CORR_WAIT) || (rsp_mode == MODE_CORR_JOG);
   assign rsp_held  = rsp_valid && !rsp_ready;

   // result register empties on reset
   `STP_ASSERT_ALWAYS_NEXT(a_rsp_empty_after_reset, clock, reset, !rsp_valid)

   // request side only stalls behind a held result
   `STP_ASSERT_NOW(a_stall_needs_result, clock, reset, !req_ready, rsp_held)

   // correction flag tracks the two correction modes
   `STP_ASSERT_NOW(a_correcting_mode, clock, reset, rsp_valid, rsp_correcting == corr_mode)

   // a held result keeps its position
   `STP_ASSERT_NEXT(a_hold_position, clock, reset, rsp_held, rsp_valid && $stable(rsp_position))

endmodule

bind stepper_turnout_positioner stp_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_stp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_position   (rsp_position),
   .rsp_mode       (rsp_mode),
   .rsp_correcting (rsp_correcting)
);
